/* hw/rtl/srem_pkg.sv */
// ----------------------------------------------------------------------------
// srem_pkg
// Types, codes and constants shared by the status register event model.
// ----------------------------------------------------------------------------
package srem_pkg;

  localparam int unsigned WordBits   = 16;
  localparam int unsigned NumGroups  = 3;
  localparam int unsigned GroupBits  = 2;

  typedef logic [WordBits-1:0] word_t;

  localparam word_t      FilterPreset = word_t'(16'h7FFF);
  localparam logic [15:0] PlainRead   = 16'h8000;
  localparam logic [7:0]  SrqBit      = 8'h40;
  localparam logic [1:0]  StbUserBits = 2'b11;

  localparam logic [2:0] SummaryPos [NumGroups] = '{3'd5, 3'd7, 3'd3};

  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_WRITE     = 3'd1,
    MODE_SET_BITS  = 3'd2,
    MODE_CLR_BITS  = 3'd3,
    MODE_CLR_STAT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    GRP_ESR  = 3'd0,
    GRP_OPER = 3'd1,
    GRP_QUES = 3'd2,
    GRP_STB  = 3'd3,
    GRP_SRE  = 3'd4
  } group_e;

  typedef enum logic [2:0] {
    REG_OPER_RISE = 3'd0,
    REG_OPER_FALL = 3'd1,
    REG_QUES_RISE = 3'd2,
    REG_QUES_FALL = 3'd3,
    REG_ESR_EN    = 3'd4,
    REG_OPER_EN   = 3'd5,
    REG_QUES_EN   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  group_sel;
    logic        word_sel;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [7:0]  status_byte;
    logic [7:0]  service_enable;
    logic        srq_pulse;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  reg_idx;
    logic [15:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [NumGroups-1:0][WordBits-1:0] rise;
    logic [NumGroups-1:0][WordBits-1:0] fall;
    logic [NumGroups-1:0][WordBits-1:0] enable;
  } cfg_regs_t;

  typedef struct packed {
    logic [NumGroups-1:0][WordBits-1:0] cond;
    logic [NumGroups-1:0][WordBits-1:0] ev;
    logic [7:0]                         stb;
    logic [7:0]                         sre;
  } state_t;

endpackage

/* hw/rtl/srem_chan_if.sv */
// ----------------------------------------------------------------------------
// srem_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface srem_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/srem_cfg.sv */
// ----------------------------------------------------------------------------
// srem_cfg
// Transition filter and enable mask registers, written over the config channel.
// ----------------------------------------------------------------------------
module srem_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  srem_chan_if.sink          cfg_i,
  output srem_pkg::cfg_regs_t regs_o
);

  srem_pkg::cfg_regs_t regs_q, regs_d;
  srem_pkg::word_t     wdata;

  assign cfg_i.ready = 1'b1;
  assign wdata       = srem_pkg::word_t'(cfg_i.payload.wdata);

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.payload.reg_idx)
        srem_pkg::REG_OPER_RISE: regs_d.rise[1]   = wdata;
        srem_pkg::REG_OPER_FALL: regs_d.fall[1]   = wdata;
        srem_pkg::REG_QUES_RISE: regs_d.rise[2]   = wdata;
        srem_pkg::REG_QUES_FALL: regs_d.fall[2]   = wdata;
        srem_pkg::REG_ESR_EN:    regs_d.enable[0] = wdata;
        srem_pkg::REG_OPER_EN:   regs_d.enable[1] = wdata;
        srem_pkg::REG_QUES_EN:   regs_d.enable[2] = wdata;
        default: ;
      endcase
    end
    // ESR has no transition filters
    regs_d.rise[0] = '0;
    regs_d.fall[0] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q         <= '0;
      regs_q.rise[1] <= srem_pkg::FilterPreset;
      regs_q.rise[2] <= srem_pkg::FilterPreset;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

/* hw/rtl/srem_update.sv */
// ----------------------------------------------------------------------------
// srem_update
// Next status state and result for one item: edge filtering, event words,
// summary bits and service request evaluation.
// ----------------------------------------------------------------------------
module srem_update (
  input  srem_pkg::in_item_t  item_i,
  input  srem_pkg::state_t    state_i,
  input  srem_pkg::cfg_regs_t regs_i,
  output srem_pkg::state_t    state_o,
  output srem_pkg::out_item_t result_o
);

  logic                           is_grp;
  logic [srem_pkg::GroupBits-1:0] gidx;
  srem_pkg::word_t                data;
  srem_pkg::word_t                cur_cond, cur_ev, cur, val;
  srem_pkg::word_t                rise, fall, next_ev;
  logic                           gw_en, changed, ev_changed, summary;
  logic [7:0]                     stb_grp, stb_pre, sre_new, others;
  logic                           srq_eval, srq_hit;
  logic [15:0]                    rv;
  srem_pkg::state_t               st;

  assign is_grp   = item_i.group_sel < 3'(srem_pkg::NumGroups);
  assign gidx     = is_grp ? item_i.group_sel[srem_pkg::GroupBits-1:0] : '0;
  assign data     = srem_pkg::word_t'(item_i.data_word);
  assign cur_cond = state_i.cond[gidx];
  assign cur_ev   = state_i.ev[gidx];
  assign cur      = item_i.word_sel ? cur_ev : cur_cond;

  always_comb begin
    case (item_i.mode)
      srem_pkg::MODE_WRITE:    val = data;
      srem_pkg::MODE_SET_BITS: val = cur | data;
      srem_pkg::MODE_CLR_BITS: val = cur & ~data;
      default:                 val = '0;
    endcase
  end

  assign gw_en = is_grp && (item_i.mode <= srem_pkg::MODE_CLR_BITS)
                 && ((item_i.mode != srem_pkg::MODE_READ) || item_i.word_sel);
  assign changed = gw_en && (cur != val) && !((gidx == '0) && !item_i.word_sel);

  assign rise    = (cur_cond ^ val) & val;
  assign fall    = (cur_cond ^ val) & cur_cond;
  assign next_ev = item_i.word_sel ? val
                 : ((rise & regs_i.rise[gidx]) | (fall & regs_i.fall[gidx]) | cur_ev);
  assign ev_changed = changed && (next_ev != cur_ev);
  assign summary    = |(next_ev & regs_i.enable[gidx]);

  always_comb begin
    stb_grp = state_i.stb;
    stb_grp[srem_pkg::SummaryPos[gidx]] = summary;
  end

  always_comb begin
    st       = state_i;
    stb_pre  = state_i.stb;
    sre_new  = state_i.sre;
    srq_eval = 1'b0;
    rv       = '0;
    unique case (item_i.mode) inside
      srem_pkg::MODE_READ, srem_pkg::MODE_WRITE,
      srem_pkg::MODE_SET_BITS, srem_pkg::MODE_CLR_BITS: begin
        unique case (item_i.group_sel) inside
          srem_pkg::GRP_ESR, srem_pkg::GRP_OPER, srem_pkg::GRP_QUES: begin
            if (item_i.mode == srem_pkg::MODE_READ) begin
              rv = 16'(cur);
            end
            if (changed && !item_i.word_sel) begin
              st.cond[gidx] = val;
            end
            if (ev_changed) begin
              st.ev[gidx] = next_ev;
              stb_pre     = stb_grp;
              srq_eval    = 1'b1;
            end
          end
          srem_pkg::GRP_STB: begin
            case (item_i.mode)
              srem_pkg::MODE_READ: rv = srem_pkg::PlainRead;
              srem_pkg::MODE_SET_BITS: begin
                stb_pre[1:0] = state_i.stb[1:0] | (item_i.data_word[1:0] & srem_pkg::StbUserBits);
                srq_eval     = 1'b1;
              end
              srem_pkg::MODE_CLR_BITS: begin
                stb_pre[1:0] = state_i.stb[1:0]
                               & ~(item_i.data_word[1:0] & srem_pkg::StbUserBits);
                srq_eval     = 1'b1;
              end
              default: ;
            endcase
          end
          srem_pkg::GRP_SRE: begin
            case (item_i.mode)
              srem_pkg::MODE_READ:     rv = srem_pkg::PlainRead;
              srem_pkg::MODE_WRITE:    sre_new = item_i.data_word[7:0];
              srem_pkg::MODE_SET_BITS: sre_new = state_i.sre | item_i.data_word[7:0];
              default:                 sre_new = state_i.sre & ~item_i.data_word[7:0];
            endcase
            if (item_i.mode != srem_pkg::MODE_READ) begin
              srq_eval = 1'b1;
            end
          end
          default: ;
        endcase
      end
      srem_pkg::MODE_CLR_STAT: begin
        stb_pre = '0;
        st.ev   = '0;
      end
      default: ;
    endcase
  end

  assign others  = stb_pre & ~srem_pkg::SrqBit & sre_new;
  assign srq_hit = srq_eval && (others != '0);

  always_comb begin
    state_o     = st;
    state_o.sre = sre_new;
    if (!srq_eval) begin
      state_o.stb = stb_pre;
    end else if (srq_hit) begin
      state_o.stb = stb_pre | srem_pkg::SrqBit;
    end else begin
      state_o.stb = stb_pre & ~srem_pkg::SrqBit;
    end
  end

  always_comb begin
    result_o.read_value     = rv;
    result_o.status_byte    = state_o.stb;
    result_o.service_enable = state_o.sre;
    result_o.srq_pulse      = srq_hit;
  end

endmodule

/* hw/rtl/status_register_event_model_core.sv */
// ----------------------------------------------------------------------------
// status_register_event_model_core
// Status reporting block: three event groups, status byte and service request.
//
//   channel | dir | payload     | accepted when
//   in_i    | in  | in_item_t   | in_i.valid & in_i.ready
//   out_o   | out | out_item_t  | out_o.valid & out_o.ready
//   cfg_i   | in  | cfg_wr_t    | cfg_i.valid & cfg_i.ready (always ready)
//
// One item per cycle sustained while out_o is ready; the result of an item
// passes the input register, then the result register, before it is valid
// on out_o.
// The state update for an item lands in the same edge that loads its result,
// so the next item in the input register sees it.
// A stalled out_o holds the result; in_i stays ready while the input
// register can move on. Reset clears state and control, leaves payload.
// ----------------------------------------------------------------------------
module status_register_event_model_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  srem_chan_if.sink   in_i,
  srem_chan_if.source out_o,
  srem_chan_if.sink   cfg_i
);

  srem_pkg::cfg_regs_t regs;
  srem_pkg::in_item_t  item_q;
  logic                item_vld_q;
  srem_pkg::out_item_t res_q, res_d;
  logic                res_vld_q;
  srem_pkg::state_t    state_q, state_d;
  logic                advance;

  srem_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  srem_update u_update (
    .item_i   (item_q),
    .state_i  (state_q),
    .regs_i   (regs),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance    = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = res_vld_q;
  assign out_o.payload = res_q;

endmodule

/* hw/rtl/srem_checker.sv */
// ----------------------------------------------------------------------------
// srem_checker
// Port-level checks on results of the status register event model.
// ----------------------------------------------------------------------------
module srem_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input srem_pkg::out_item_t out_payload_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result dropped or changed while stalled");

  a_srq_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.srq_pulse |-> out_payload_i.status_byte[6])
    else $error("request pulse without SRQ bit");

  a_srq_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.srq_pulse
    |-> (out_payload_i.status_byte & out_payload_i.service_enable & 8'hBF) != 8'h00)
    else $error("request pulse without enabled status bit");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind status_register_event_model_core srem_checker u_srem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
